FILE: rtl/ffba_pkg.sv
// Shared constants, codes and payload types of the first-fit block allocator.
package ffba_pkg;

    localparam int POOL_BYTES   = 1024 * 1024;
    localparam int MAX_BLOCKS   = 64;
    localparam int HEADER_BYTES = 32;
    localparam int ALIGN_BYTES  = 8;
    localparam int MIN_PAYLOAD  = 4;

    localparam int ADDR_W = 20;
    localparam int SIZE_W = 21;
    localparam int WANT_W = 22;
    localparam int CNT_W  = $clog2(MAX_BLOCKS) + 1;

    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NO_FIT   = 2'd1;
    localparam logic [1:0] ST_BAD_FREE = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEL,
        S_UPD
    } t_state;

    typedef struct packed {
        logic              kind;
        logic [SIZE_W-1:0] request_bytes;
        logic [ADDR_W-1:0] user_address;
    } t_request;

    typedef struct packed {
        logic [1:0]        status;
        logic [ADDR_W-1:0] granted_address;
        logic [SIZE_W-1:0] granted_bytes;
    } t_result;

    typedef struct packed {
        logic              valid;
        logic              in_use;
        logic [ADDR_W-1:0] start;
        logic [ADDR_W-1:0] payload;
    } t_cell_state;

    typedef struct packed {
        logic              kind;
        logic [WANT_W-1:0] want;
        logic [ADDR_W-1:0] addr;
    } t_cell_req;

    typedef struct packed {
        logic              en;
        logic              kind;
        logic              ok;
        logic              split;
        logic              mprev;
        logic              mnext;
        logic [WANT_W-1:0] want;
    } t_cell_upd;

endpackage

FILE: rtl/ffba_cell.sv
// One table entry of the allocator: holds a block and rewrites it from its neighbors.
module ffba_cell (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  ffba_pkg::t_cell_state i_init,
    input  logic                  i_cmp_en,
    input  ffba_pkg::t_cell_req   i_req,
    input  logic                  i_sel_en,
    input  logic                  i_seen,
    output logic                  o_seen,
    output logic                  o_first,
    output logic                  o_hit,
    input  logic                  i_hit_left,
    input  logic                  i_hit_right,
    input  ffba_pkg::t_cell_upd   i_upd,
    input  ffba_pkg::t_cell_state i_left,
    input  ffba_pkg::t_cell_state i_right1,
    input  ffba_pkg::t_cell_state i_right2,
    output ffba_pkg::t_cell_state o_state
);

    ffba_pkg::t_cell_state r_state;
    ffba_pkg::t_cell_state n_state;
    logic                  r_cand;
    logic                  r_hit;
    logic                  r_above;

    logic                          w_cand;
    logic [ffba_pkg::ADDR_W-1:0]   w_user;
    logic [ffba_pkg::WANT_W-1:0]   w_pay_ext;
    logic [ffba_pkg::ADDR_W-1:0]   w_high_start;
    logic [ffba_pkg::ADDR_W-1:0]   w_rest;
    logic [ffba_pkg::ADDR_W-1:0]   w_add1;
    logic [ffba_pkg::ADDR_W-1:0]   w_add2;

    always_comb begin
        w_user    = r_state.start + ffba_pkg::ADDR_W'(ffba_pkg::HEADER_BYTES);
        w_pay_ext = ffba_pkg::WANT_W'(r_state.payload);
        if (i_req.kind == ffba_pkg::KIND_ALLOC) begin
            w_cand = r_state.valid && !r_state.in_use && (w_pay_ext >= i_req.want);
        end else begin
            w_cand = r_state.valid && (w_user == i_req.addr);
        end
    end

    // The split-off remainder is built from the old contents of the chosen block.
    assign w_high_start = i_left.start + ffba_pkg::ADDR_W'(ffba_pkg::HEADER_BYTES)
                          + i_upd.want[ffba_pkg::ADDR_W-1:0];
    assign w_rest       = i_left.payload - i_upd.want[ffba_pkg::ADDR_W-1:0]
                          - ffba_pkg::ADDR_W'(ffba_pkg::HEADER_BYTES);
    assign w_add1       = i_right1.payload + ffba_pkg::ADDR_W'(ffba_pkg::HEADER_BYTES);
    assign w_add2       = i_right2.payload + ffba_pkg::ADDR_W'(ffba_pkg::HEADER_BYTES);

    always_comb begin
        n_state = r_state;
        if (i_upd.en && i_upd.ok) begin
            if (i_upd.kind == ffba_pkg::KIND_ALLOC) begin
                if (r_hit) begin
                    n_state.in_use = 1'b1;
                    if (i_upd.split) begin
                        n_state.payload = i_upd.want[ffba_pkg::ADDR_W-1:0];
                    end
                end else if (i_upd.split && i_hit_left) begin
                    n_state = '{valid: 1'b1, in_use: 1'b0, start: w_high_start,
                                payload: w_rest};
                end else if (i_upd.split && r_above) begin
                    n_state = i_left;
                end
            end else if (i_upd.mprev) begin
                // The freed block folds into the free block below it.
                if (i_hit_right) begin
                    n_state.payload = r_state.payload + w_add1
                                      + (i_upd.mnext ? w_add2 : '0);
                end else if (r_hit || r_above) begin
                    n_state = i_upd.mnext ? i_right2 : i_right1;
                end
            end else begin
                if (r_hit) begin
                    n_state.in_use  = 1'b0;
                    n_state.payload = r_state.payload + (i_upd.mnext ? w_add1 : '0);
                end else if (r_above && i_upd.mnext) begin
                    n_state = i_right1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= i_init;
            r_cand  <= 1'b0;
            r_hit   <= 1'b0;
            r_above <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cmp_en) begin
                r_cand <= w_cand;
            end
            if (i_sel_en) begin
                r_hit   <= o_first;
                r_above <= i_seen;
            end
        end
    end

    assign o_first = r_cand && !i_seen;
    assign o_seen  = i_seen || r_cand;
    assign o_hit   = r_hit;
    assign o_state = r_state;

endmodule

FILE: rtl/first_fit_block_allocator.sv
// Top level of the first-fit block allocator: request sequencer, cell row and result register.
// The result and its strobe are registered when the update step ends; busy stays high after
// acceptance until the update is done, so a new transaction waits for the one before it.
// The three steps are the parallel compare in every cell, the first-candidate chain across
// the 64 cells with the neighbor gather, and the shift or merge update of the row.
// Reset is synchronous: the table returns to one free block spanning the pool, at once.
module first_fit_block_allocator (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  ffba_pkg::t_request i_request,
    output logic               o_done,
    output ffba_pkg::t_result  o_result
);

    localparam int N = ffba_pkg::MAX_BLOCKS;

    ffba_pkg::t_state r_state;
    ffba_pkg::t_state n_state;
    logic             r_done;
    logic [ffba_pkg::CNT_W-1:0] r_count;
    logic [ffba_pkg::CNT_W-1:0] n_count;

    logic                        r_kind;
    logic [ffba_pkg::WANT_W-1:0] r_want;
    logic                        r_found;
    logic                        r_hit_use;
    logic [ffba_pkg::ADDR_W-1:0] r_hit_start;
    logic [ffba_pkg::ADDR_W-1:0] r_hit_pay;
    logic                        r_prev_free;
    logic [ffba_pkg::ADDR_W-1:0] r_prev_start;
    logic [ffba_pkg::ADDR_W-1:0] r_prev_pay;
    logic                        r_next_free;
    logic [ffba_pkg::ADDR_W-1:0] r_next_pay;
    ffba_pkg::t_result           r_result;
    ffba_pkg::t_result           n_result;

    logic w_cmp_en;
    logic w_sel_en;
    logic w_upd_en;
    logic w_busy;

    logic [ffba_pkg::WANT_W-1:0] w_want;
    ffba_pkg::t_cell_req         w_req;
    ffba_pkg::t_cell_upd         w_upd;
    logic                        w_split;
    logic                        w_ok;
    logic [ffba_pkg::SIZE_W-1:0] w_next_add;

    logic                        g_found;
    logic                        g_hit_use;
    logic [ffba_pkg::ADDR_W-1:0] g_hit_start;
    logic [ffba_pkg::ADDR_W-1:0] g_hit_pay;
    logic                        g_prev_free;
    logic [ffba_pkg::ADDR_W-1:0] g_prev_start;
    logic [ffba_pkg::ADDR_W-1:0] g_prev_pay;
    logic                        g_next_free;
    logic [ffba_pkg::ADDR_W-1:0] g_next_pay;

    ffba_pkg::t_cell_state w_state [N];
    ffba_pkg::t_cell_state w_init  [N];
    ffba_pkg::t_cell_state w_left  [N];
    ffba_pkg::t_cell_state w_r1    [N];
    ffba_pkg::t_cell_state w_r2    [N];
    logic [N:0]            w_seen;
    logic [N-1:0]          w_first;
    logic [N-1:0]          w_hit;
    logic [N-1:0]          w_hl;
    logic [N-1:0]          w_hr;
    logic [N-1:0]          w_valid;

    // Sizes round up to the alignment; the sum is wide enough for the largest request.
    assign w_want = (ffba_pkg::WANT_W'(i_request.request_bytes)
                     + ffba_pkg::WANT_W'(ffba_pkg::ALIGN_BYTES - 1))
                    & ~ffba_pkg::WANT_W'(ffba_pkg::ALIGN_BYTES - 1);

    assign w_req = '{kind: i_request.kind, want: w_want, addr: i_request.user_address};

    assign w_seen[0] = 1'b0;

    genvar gi;
    generate
        for (gi = 0; gi < N; gi++) begin : g_cell
            if (gi == 0) begin : g_first
                assign w_init[gi] = '{valid: 1'b1, in_use: 1'b0, start: '0,
                    payload: ffba_pkg::ADDR_W'(ffba_pkg::POOL_BYTES - ffba_pkg::HEADER_BYTES)};
                assign w_left[gi] = '0;
                assign w_hl[gi]   = 1'b0;
            end else begin : g_rest
                assign w_init[gi] = '0;
                assign w_left[gi] = w_state[gi-1];
                assign w_hl[gi]   = w_hit[gi-1];
            end
            if (gi < N - 1) begin : g_r1
                assign w_r1[gi] = w_state[gi+1];
                assign w_hr[gi] = w_hit[gi+1];
            end else begin : g_r1_end
                assign w_r1[gi] = '0;
                assign w_hr[gi] = 1'b0;
            end
            if (gi < N - 2) begin : g_r2
                assign w_r2[gi] = w_state[gi+2];
            end else begin : g_r2_end
                assign w_r2[gi] = '0;
            end

            ffba_cell u_cell (
                .i_clk       (i_clk),
                .i_rst_n     (i_rst_n),
                .i_init      (w_init[gi]),
                .i_cmp_en    (w_cmp_en),
                .i_req       (w_req),
                .i_sel_en    (w_sel_en),
                .i_seen      (w_seen[gi]),
                .o_seen      (w_seen[gi+1]),
                .o_first     (w_first[gi]),
                .o_hit       (w_hit[gi]),
                .i_hit_left  (w_hl[gi]),
                .i_hit_right (w_hr[gi]),
                .i_upd       (w_upd),
                .i_left      (w_left[gi]),
                .i_right1    (w_r1[gi]),
                .i_right2    (w_r2[gi]),
                .o_state     (w_state[gi])
            );

            assign w_valid[gi] = w_state[gi].valid;
        end
    endgenerate

    // Gather the chosen block and its two neighbors; at most one first bit is set.
    always_comb begin
        g_found      = 1'b0;
        g_hit_use    = 1'b0;
        g_hit_start  = '0;
        g_hit_pay    = '0;
        g_prev_free  = 1'b0;
        g_prev_start = '0;
        g_prev_pay   = '0;
        g_next_free  = 1'b0;
        g_next_pay   = '0;
        for (int i = 0; i < N; i++) begin
            if (w_first[i]) begin
                g_found     = 1'b1;
                g_hit_use   = g_hit_use | w_state[i].in_use;
                g_hit_start = g_hit_start | w_state[i].start;
                g_hit_pay   = g_hit_pay | w_state[i].payload;
            end
        end
        for (int i = 1; i < N; i++) begin
            if (w_first[i]) begin
                g_prev_free  = g_prev_free | (w_state[i-1].valid & ~w_state[i-1].in_use);
                g_prev_start = g_prev_start | w_state[i-1].start;
                g_prev_pay   = g_prev_pay | w_state[i-1].payload;
            end
        end
        for (int i = 0; i < N - 1; i++) begin
            if (w_first[i]) begin
                g_next_free = g_next_free | (w_state[i+1].valid & ~w_state[i+1].in_use);
                g_next_pay  = g_next_pay | w_state[i+1].payload;
            end
        end
    end

    // Sequencer: compare on acceptance, pick the first candidate, then update the row.
    always_comb begin
        n_state  = r_state;
        w_cmp_en = 1'b0;
        w_sel_en = 1'b0;
        w_upd_en = 1'b0;
        w_busy   = 1'b1;
        case (r_state)
            ffba_pkg::S_IDLE: begin
                w_busy = 1'b0;
                if (start) begin
                    w_cmp_en = 1'b1;
                    n_state  = ffba_pkg::S_SEL;
                end
            end
            ffba_pkg::S_SEL: begin
                w_sel_en = 1'b1;
                n_state  = ffba_pkg::S_UPD;
            end
            ffba_pkg::S_UPD: begin
                w_upd_en = 1'b1;
                n_state  = ffba_pkg::S_IDLE;
            end
            default: begin
                n_state = ffba_pkg::S_IDLE;
            end
        endcase
    end

    assign busy = w_busy;

    always_comb begin
        w_split = (r_kind == ffba_pkg::KIND_ALLOC) && r_found
                  && (r_count < ffba_pkg::CNT_W'(ffba_pkg::MAX_BLOCKS))
                  && (ffba_pkg::WANT_W'(r_hit_pay) >= r_want
                      + ffba_pkg::WANT_W'(ffba_pkg::HEADER_BYTES + ffba_pkg::MIN_PAYLOAD));
        w_ok = (r_kind == ffba_pkg::KIND_ALLOC) ? r_found : (r_found && r_hit_use);
        w_upd = '{en: w_upd_en, kind: r_kind, ok: w_ok, split: w_split,
                  mprev: r_prev_free, mnext: r_next_free, want: r_want};
        w_next_add = r_next_free
                     ? (ffba_pkg::SIZE_W'(r_next_pay) + ffba_pkg::SIZE_W'(ffba_pkg::HEADER_BYTES))
                     : '0;

        n_result = '0;
        n_count  = r_count;
        if (r_kind == ffba_pkg::KIND_ALLOC) begin
            if (!r_found) begin
                n_result.status = ffba_pkg::ST_NO_FIT;
            end else begin
                n_result.status          = ffba_pkg::ST_OK;
                n_result.granted_address = r_hit_start
                                           + ffba_pkg::ADDR_W'(ffba_pkg::HEADER_BYTES);
                n_result.granted_bytes   = w_split ? r_want[ffba_pkg::SIZE_W-1:0]
                                                   : ffba_pkg::SIZE_W'(r_hit_pay);
                if (w_split) begin
                    n_count = r_count + ffba_pkg::CNT_W'(1);
                end
            end
        end else begin
            if (!w_ok) begin
                n_result.status = ffba_pkg::ST_BAD_FREE;
            end else begin
                n_result.status = ffba_pkg::ST_OK;
                if (r_prev_free) begin
                    n_result.granted_address = r_prev_start
                                               + ffba_pkg::ADDR_W'(ffba_pkg::HEADER_BYTES);
                    n_result.granted_bytes   = ffba_pkg::SIZE_W'(r_prev_pay)
                        + ffba_pkg::SIZE_W'(r_hit_pay)
                        + ffba_pkg::SIZE_W'(ffba_pkg::HEADER_BYTES) + w_next_add;
                end else begin
                    n_result.granted_address = r_hit_start
                                               + ffba_pkg::ADDR_W'(ffba_pkg::HEADER_BYTES);
                    n_result.granted_bytes   = ffba_pkg::SIZE_W'(r_hit_pay) + w_next_add;
                end
                n_count = r_count - ffba_pkg::CNT_W'(r_prev_free)
                          - ffba_pkg::CNT_W'(r_next_free);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ffba_pkg::S_IDLE;
            r_done  <= 1'b0;
            r_count <= ffba_pkg::CNT_W'(1);
        end else begin
            r_state <= n_state;
            r_done  <= w_upd_en;
            if (w_upd_en) begin
                r_count <= n_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_cmp_en) begin
            r_kind <= i_request.kind;
            r_want <= w_want;
        end
        if (w_sel_en) begin
            r_found      <= g_found;
            r_hit_use    <= g_hit_use;
            r_hit_start  <= g_hit_start;
            r_hit_pay    <= g_hit_pay;
            r_prev_free  <= g_prev_free;
            r_prev_start <= g_prev_start;
            r_prev_pay   <= g_prev_pay;
            r_next_free  <= g_next_free;
            r_next_pay   <= g_next_pay;
        end
        if (w_upd_en) begin
            r_result <= n_result;
        end
    end

    assign o_done   = r_done;
    assign o_result = r_result;

`ifndef SYNTH
    a_hit_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_hit))
        else $error("more than one cell marked as the chosen block");

    a_count_matches_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(w_valid) == int'(r_count))
        else $error("block count disagrees with the valid cells");

    a_valid_packed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_valid[0] && ((w_valid & (w_valid + {{(N-1){1'b0}}, 1'b1})) == '0))
        else $error("valid cells are not packed at the low end of the row");

    a_done_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##3 o_done)
        else $error("result strobe missing three cycles after a transaction");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_result.status != ffba_pkg::ST_OK))
        |-> (o_result.granted_address == '0 && o_result.granted_bytes == '0))
        else $error("failed transaction reports a nonzero block");
`endif

endmodule

FILE: tb/sv/ffba_grant_checker.sv
// Checker that predicts every allocator result and compares it with what the block returns.
`timescale 1ns / 100ps

module ffba_grant_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic               i_busy,
    input  ffba_pkg::t_request i_request,
    input  logic               i_done,
    input  ffba_pkg::t_result  i_result,
    output int                 o_errors,
    output int                 o_pending
);
    import ffba_pkg::*;

    // Shadow copy of the block table, kept in address order.
    logic [ADDR_W-1:0] cell_start   [MAX_BLOCKS];
    logic [ADDR_W-1:0] cell_payload [MAX_BLOCKS];
    logic              cell_taken   [MAX_BLOCKS];
    int                cell_count;

    t_result grant_q [$];
    int      mismatches = 0;
    int      outstanding = 0;

    assign o_errors  = mismatches;
    assign o_pending = outstanding;

    function automatic void clear_table();
        for (int k = 0; k < MAX_BLOCKS; k++) begin
            cell_start[k]   = '0;
            cell_payload[k] = '0;
            cell_taken[k]   = 1'b0;
        end
        cell_payload[0] = ADDR_W'(POOL_BYTES - HEADER_BYTES);
        cell_count      = 1;
    endfunction

    function automatic void drop_cell(int k);
        for (int j = k; j + 1 < cell_count; j++) begin
            cell_start[j]   = cell_start[j + 1];
            cell_payload[j] = cell_payload[j + 1];
            cell_taken[j]   = cell_taken[j + 1];
        end
        cell_count--;
        cell_start[cell_count]   = '0;
        cell_payload[cell_count] = '0;
        cell_taken[cell_count]   = 1'b0;
    endfunction

    // Applies one request to the shadow table and returns the grant it should produce.
    function automatic t_result apply_request(t_request r);
        t_result res;
        int      want;
        int      hit;
        int      rest;
        res = '0;
        hit = cell_count;
        if (r.kind == KIND_ALLOC) begin
            want = (int'(r.request_bytes) + ALIGN_BYTES - 1) / ALIGN_BYTES * ALIGN_BYTES;
            for (int k = 0; k < cell_count; k++) begin
                if (hit == cell_count && !cell_taken[k] && int'(cell_payload[k]) >= want) begin
                    hit = k;
                end
            end
            if (hit == cell_count) begin
                res.status = ST_NO_FIT;
            end else begin
                // A full table cannot take the split-off remainder, so the whole block goes.
                if (int'(cell_payload[hit]) >= want + HEADER_BYTES + MIN_PAYLOAD
                        && cell_count < MAX_BLOCKS) begin
                    rest = int'(cell_payload[hit]) - want - HEADER_BYTES;
                    for (int k = cell_count; k > hit + 1; k--) begin
                        cell_start[k]   = cell_start[k - 1];
                        cell_payload[k] = cell_payload[k - 1];
                        cell_taken[k]   = cell_taken[k - 1];
                    end
                    cell_start[hit + 1]   = cell_start[hit] + ADDR_W'(HEADER_BYTES + want);
                    cell_payload[hit + 1] = ADDR_W'(rest);
                    cell_taken[hit + 1]   = 1'b0;
                    cell_payload[hit]     = ADDR_W'(want);
                    cell_count++;
                end
                cell_taken[hit]     = 1'b1;
                res.status          = ST_OK;
                res.granted_address = cell_start[hit] + ADDR_W'(HEADER_BYTES);
                res.granted_bytes   = SIZE_W'(cell_payload[hit]);
            end
        end else begin
            for (int k = 0; k < cell_count; k++) begin
                if (hit == cell_count && cell_start[k] + ADDR_W'(HEADER_BYTES) == r.user_address) begin
                    hit = k;
                end
            end
            if (hit == cell_count || !cell_taken[hit]) begin
                res.status = ST_BAD_FREE;
            end else begin
                cell_taken[hit] = 1'b0;
                if (hit > 0 && !cell_taken[hit - 1]) begin
                    cell_payload[hit - 1] = cell_payload[hit - 1] + cell_payload[hit]
                                          + ADDR_W'(HEADER_BYTES);
                    drop_cell(hit);
                    hit--;
                end
                if (hit + 1 < cell_count && !cell_taken[hit + 1]) begin
                    cell_payload[hit] = cell_payload[hit] + cell_payload[hit + 1]
                                      + ADDR_W'(HEADER_BYTES);
                    drop_cell(hit + 1);
                end
                res.status          = ST_OK;
                res.granted_address = cell_start[hit] + ADDR_W'(HEADER_BYTES);
                res.granted_bytes   = SIZE_W'(cell_payload[hit]);
            end
        end
        return res;
    endfunction

    task automatic note_failure(string what, t_result want, t_result got);
        mismatches++;
        if (mismatches <= 10) begin
            $display("%0t: %s: expected status %0d addr 0x%05h bytes %0d, got status %0d addr 0x%05h bytes %0d",
                     $realtime, what, want.status, want.granted_address, want.granted_bytes,
                     got.status, got.granted_address, got.granted_bytes);
        end
    endtask

    // Results are retired before new transactions are predicted, since a result
    // always belongs to an earlier request.
    always @(posedge i_clk) begin : watch
        t_result want;
        if (!i_rst_n) begin
            clear_table();
            grant_q.delete();
        end else begin
            if (i_done) begin
                if (grant_q.size() == 0) begin
                    note_failure("result with no request outstanding", '0, i_result);
                end else begin
                    want = grant_q.pop_front();
                    if (want.status != i_result.status
                            || want.granted_address != i_result.granted_address
                            || want.granted_bytes != i_result.granted_bytes) begin
                        note_failure("result mismatch", want, i_result);
                    end
                end
            end
            if (i_start && !i_busy) begin
                grant_q.push_back(apply_request(i_request));
            end
        end
        outstanding = grant_q.size();
    end

endmodule

FILE: tb/sv/tb.sv
// Top of the allocator testbench: clock, reset, request stimulus and the final verdict.
`timescale 1ns / 100ps

module tb;
    import ffba_pkg::*;

    localparam int RANDOM_ITEMS = 530;
    localparam int CYCLE_LIMIT  = 200000;

    logic     i_clk     = 1'b0;
    logic     i_rst_n   = 1'b0;
    logic     start     = 1'b0;
    logic     busy;
    t_request i_request = '0;
    logic     o_done;
    t_result  o_result;

    int errors;
    int pending;
    int cycles = 0;
    int issued = 0;

    // Addresses believed to be allocated, and ones that were freed, to steer the frees.
    logic [ADDR_W-1:0] live_addr  [$];
    logic [ADDR_W-1:0] freed_addr [$];
    logic              kind_q     [$];

    always #1 i_clk = ~i_clk;

    first_fit_block_allocator i_dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .start     (start),
        .busy      (busy),
        .i_request (i_request),
        .o_done    (o_done),
        .o_result  (o_result)
    );

    ffba_grant_checker u_checker (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start),
        .i_busy    (busy),
        .i_request (i_request),
        .i_done    (o_done),
        .i_result  (o_result),
        .o_errors  (errors),
        .o_pending (pending)
    );

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("first_fit_block_allocator test failed");
            $finish;
        end
    end

    always @(posedge i_clk) begin : track_grants
        logic kind;
        if (i_rst_n) begin
            if (o_done && kind_q.size() > 0) begin
                kind = kind_q.pop_front();
                if (kind == KIND_ALLOC && o_result.status == ST_OK) begin
                    live_addr.push_back(o_result.granted_address);
                end
            end
            if (start && !busy) begin
                kind_q.push_back(i_request.kind);
            end
        end
    end

    function automatic t_request alloc_req(int bytes);
        t_request r;
        r.kind          = KIND_ALLOC;
        r.request_bytes = SIZE_W'(bytes);
        r.user_address  = ADDR_W'($urandom);
        return r;
    endfunction

    function automatic t_request free_req(int addr);
        t_request r;
        r.kind          = KIND_FREE;
        r.request_bytes = SIZE_W'($urandom);
        r.user_address  = ADDR_W'(addr);
        return r;
    endfunction

    // Mode 1 asks for small blocks only so that the table fills up; mode 3 drains it.
    function automatic t_request make_request(int mode);
        t_request r;
        int       target;
        int       roll;
        int       pick;
        r.kind          = KIND_ALLOC;
        r.request_bytes = SIZE_W'($urandom);
        r.user_address  = ADDR_W'($urandom);
        case (mode)
            0:       target = 12;
            1:       target = 70;
            2:       target = 40;
            default: target = 0;
        endcase
        roll = $urandom_range(0, 99);
        if (live_addr.size() < target ? roll < (mode == 1 ? 90 : 70) : roll < 30) begin
            roll = $urandom_range(0, 99);
            if (mode == 1 || roll < 40) begin
                r.request_bytes = SIZE_W'($urandom_range(0, 64));
            end else if (roll < 70) begin
                r.request_bytes = SIZE_W'($urandom_range(65, 4096));
            end else if (roll < 88) begin
                r.request_bytes = SIZE_W'($urandom_range(4097, 65536));
            end else if (roll < 95) begin
                r.request_bytes = SIZE_W'($urandom_range(65537, 1048576));
            end else begin
                r.request_bytes = SIZE_W'($urandom_range(1048577, 2097151));
            end
        end else begin
            r.kind = KIND_FREE;
            roll   = $urandom_range(0, 99);
            if (roll < 80 && live_addr.size() > 0) begin
                pick           = $urandom_range(0, live_addr.size() - 1);
                r.user_address = live_addr[pick];
                freed_addr.push_back(live_addr[pick]);
                live_addr.delete(pick);
            end else if (roll < 90 && freed_addr.size() > 0) begin
                r.user_address = freed_addr[$urandom_range(0, freed_addr.size() - 1)];
            end else if (roll < 95 && live_addr.size() > 0) begin
                r.user_address = ADDR_W'(live_addr[$urandom_range(0, live_addr.size() - 1)]
                                         + 8);
            end
        end
        return r;
    endfunction

    // Drives one transaction, waits for it to be taken, then sometimes idles for a while.
    task automatic issue(t_request r);
        int gap;
        int roll;
        start     <= 1'b1;
        i_request <= r;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        issued++;
        roll = $urandom_range(0, 99);
        if ((issued / 50) % 4 == 1 || roll < 65) begin
            gap = 0;
        end else if (roll < 92) begin
            gap = $urandom_range(1, 3);
        end else begin
            gap = $urandom_range(8, 40);
        end
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        wait (pending == 0);
    endtask

    initial begin
        int mode_plan [5];
        mode_plan = '{0, 1, 2, 1, 3};
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Zero, odd and exact sizes split the first block into payloads at 32, 64, 104, 144.
        issue(alloc_req(0));
        issue(alloc_req(1));
        issue(alloc_req(8));
        issue(alloc_req(9));
        issue(alloc_req(2097151));
        issue(alloc_req(1048576));
        issue(free_req(0));
        issue(free_req(1048575));
        issue(free_req(64));
        issue(free_req(64));
        issue(free_req(32));
        issue(free_req(144));
        issue(free_req(104));
        // The whole pool as one request leaves no room to split.
        issue(alloc_req(POOL_BYTES - HEADER_BYTES));
        issue(alloc_req(0));
        issue(free_req(32));
        // This size leaves just enough for a header and a small tail block.
        issue(alloc_req(1048504));
        issue(alloc_req(8));
        issue(free_req(1048568));
        issue(free_req(32));
        issue(free_req(1048568));
        drain();
        live_addr.delete();
        freed_addr.delete();

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == RANDOM_ITEMS / 2) begin
                drain();
            end
            issue(make_request(mode_plan[(n / 110) % 5]));
        end

        drain();
        repeat (8) @(posedge i_clk);
        if (errors == 0 && pending == 0) begin
            $display("first_fit_block_allocator test passed");
        end else begin
            $display("first_fit_block_allocator test failed");
        end
        $finish;
    end

endmodule
